// ----- rtl/core/rpsb_pkg.sv -----
`default_nettype none
package rpsb_pkg;

  localparam int GridSize = 64;
  localparam int BinCount = 56;
  localparam int IdxW     = 6;
  localparam int BinW     = 6;
  localparam int SumW     = 50;
  localparam int CntW     = 19;
  localparam int MeanW    = 32;
  localparam int Mag2W    = 12;
  localparam int PowW     = 33;
  localparam int SqW      = 32;
  localparam int RemW     = CntW + 1;
  localparam int DivCntW  = 6;
  localparam int SqrtStW  = 3;
  localparam int EntryW   = SumW + CntW;

  localparam logic [IdxW-1:0] HalfGrid = IdxW'(GridSize / 2);
  localparam logic [BinW-1:0] LastBin  = BinW'(BinCount - 1);

  // Request command codes.
  localparam logic CmdAccumulate = 1'b0;
  localparam logic CmdFinish     = 1'b1;

  typedef struct packed {
    logic                    command;
    logic [IdxW-1:0]         x_index;
    logic [IdxW-1:0]         y_index;
    logic [IdxW-1:0]         z_index;
    logic signed [15:0]      real_part;
    logic signed [15:0]      imag_part;
  } req_t;

  typedef struct packed {
    logic [BinW-1:0]  bin_index;
    logic [MeanW-1:0] mean_power;
    logic [CntW-1:0]  point_count;
    logic             last;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic sqrt_step;
    logic acc_rd;
    logic acc_wr;
    logic emit_init;
    logic emit_rd;
    logic div_load;
    logic div_step;
    logic emit_out;
  } dp_cmd_t;

  typedef struct packed {
    logic z_ok;
    logic sqrt_last;
    logic div_last;
    logic last_bin;
  } dp_sts_t;

  typedef enum logic [7:0] {
    StIdle    = 8'b0000_0001,
    StPrep    = 8'b0000_0010,
    StSqrt    = 8'b0000_0100,
    StAccRd   = 8'b0000_1000,
    StAccWr   = 8'b0001_0000,
    StEmitRd  = 8'b0010_0000,
    StDivLd   = 8'b0100_0000,
    StDiv     = 8'b1000_0000
  } state_e;

endpackage
`default_nettype wire

// ----- rtl/core/rpsb_ram.sv -----
`default_nettype none
module rpsb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/core/rpsb_ctrl.sv -----
`default_nettype none
module rpsb_ctrl import rpsb_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire logic    finish_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o,
  output logic         busy_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (finish_i) begin
            cmd_o.emit_init = 1'b1;
            state_d = StEmitRd;
          end else begin
            state_d = StPrep;
          end
        end
      end
      StPrep: begin
        cmd_o.prep = 1'b1;
        state_d = sts_i.z_ok ? StSqrt : StIdle;
      end
      StSqrt: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.sqrt_last) begin
          state_d = StAccRd;
        end
      end
      StAccRd: begin
        cmd_o.acc_rd = 1'b1;
        state_d = StAccWr;
      end
      StAccWr: begin
        cmd_o.acc_wr = 1'b1;
        state_d = StIdle;
      end
      StEmitRd: begin
        cmd_o.emit_rd = 1'b1;
        state_d = StDivLd;
      end
      StDivLd: begin
        cmd_o.div_load = 1'b1;
        state_d = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          cmd_o.emit_out = 1'b1;
          state_d = sts_i.last_bin ? StIdle : StEmitRd;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

endmodule
`default_nettype wire

// ----- rtl/core/rpsb_datapath.sv -----
`default_nettype none
module rpsb_datapath import rpsb_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire req_t    req_i,
  input  wire dp_cmd_t cmd_i,
  output dp_sts_t      sts_o,
  output rsp_t         rsp_o,
  output logic         rsp_valid_o
);

  req_t               req_q;
  logic [Mag2W-1:0]   mag2_q;
  logic [SqW-1:0]     re2_q, im2_q;
  logic               dbl_q;
  logic [PowW-1:0]    power_q;
  logic [BinW-1:0]    root_q;
  logic [SqrtStW-1:0] sbit_q;
  logic [BinW-1:0]    bin_q;
  logic [BinCount-1:0] valid_q;
  logic [SumW-1:0]    dividend_q, quot_q;
  logic [CntW-1:0]    divisor_q;
  logic [CntW-1:0]    rem_q;
  logic [DivCntW-1:0] dcnt_q;
  rsp_t               rsp_q;
  logic               rsp_valid_q;

  logic [IdxW-1:0]    ax, ay;
  logic [Mag2W-1:0]   mag2_d;
  logic [BinW-1:0]    trial;
  logic [Mag2W-1:0]   trial_sq;
  logic [BinW-1:0]    root_next;
  logic [EntryW-1:0]  rdata, wdata;
  logic [SumW-1:0]    old_sum, new_sum;
  logic [CntW-1:0]    old_cnt, new_cnt;
  logic [RemW-1:0]    rem_sh, rem_sub;
  logic               rem_ge;
  logic [SumW-1:0]    quot_next;
  logic [MeanW-1:0]   mean;

  // Fold indices above half the grid to their negative-frequency magnitude.
  assign ax = (req_q.x_index <= HalfGrid) ? req_q.x_index : IdxW'(0) - req_q.x_index;
  assign ay = (req_q.y_index <= HalfGrid) ? req_q.y_index : IdxW'(0) - req_q.y_index;
  assign mag2_d = Mag2W'(ax * ax) + Mag2W'(ay * ay)
                + Mag2W'(req_q.z_index * req_q.z_index);

  assign trial     = root_q | BinW'(1 << sbit_q);
  assign trial_sq  = Mag2W'(trial * trial);
  assign root_next = (trial_sq <= mag2_q) ? trial : root_q;

  assign old_sum = valid_q[bin_q] ? rdata[EntryW-1:CntW] : '0;
  assign old_cnt = valid_q[bin_q] ? rdata[CntW-1:0] : '0;
  assign new_sum = old_sum + SumW'(power_q);
  assign new_cnt = old_cnt + (dbl_q ? CntW'(2) : CntW'(1));
  assign wdata   = {new_sum, new_cnt};

  assign rem_sh    = {rem_q, dividend_q[SumW-1]};
  assign rem_ge    = rem_sh >= {1'b0, divisor_q};
  assign rem_sub   = rem_sh - {1'b0, divisor_q};
  assign quot_next = {quot_q[SumW-2:0], rem_ge};

  assign mean = (divisor_q == '0) ? '0 :
                (quot_next[SumW-1:MeanW] != '0) ? '1 : quot_next[MeanW-1:0];

  rpsb_ram #(
    .Width(EntryW),
    .Depth(BinCount)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (cmd_i.acc_wr),
    .waddr_i (bin_q),
    .wdata_i (wdata),
    .re_i    (cmd_i.acc_rd | cmd_i.emit_rd),
    .raddr_i (bin_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.prep) begin
      mag2_q <= mag2_d;
      re2_q  <= SqW'(req_q.real_part * req_q.real_part);
      im2_q  <= SqW'(req_q.imag_part * req_q.imag_part);
      dbl_q  <= (req_q.z_index != '0) && (req_q.z_index < HalfGrid);
      root_q <= '0;
      sbit_q <= SqrtStW'(BinW - 1);
    end
    if (cmd_i.sqrt_step) begin
      root_q  <= root_next;
      sbit_q  <= sbit_q - SqrtStW'(1);
      power_q <= (PowW'(re2_q) + PowW'(im2_q)) << dbl_q;
    end
    if (cmd_i.div_load) begin
      dividend_q <= valid_q[bin_q] ? rdata[EntryW-1:CntW] : '0;
      divisor_q  <= valid_q[bin_q] ? rdata[CntW-1:0] : '0;
      rem_q      <= '0;
      quot_q     <= '0;
      dcnt_q     <= DivCntW'(SumW - 1);
    end
    if (cmd_i.div_step) begin
      dividend_q <= dividend_q << 1;
      rem_q      <= rem_ge ? rem_sub[CntW-1:0] : rem_sh[CntW-1:0];
      quot_q     <= quot_next;
      dcnt_q     <= dcnt_q - DivCntW'(1);
    end
    if (cmd_i.emit_out) begin
      rsp_q.bin_index   <= bin_q;
      rsp_q.mean_power  <= mean;
      rsp_q.point_count <= divisor_q;
      rsp_q.last        <= (bin_q == LastBin);
    end
  end

  // Bin address: set by the square root on accumulate, swept on finish.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q       <= '0;
      valid_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= cmd_i.emit_out;
      if (cmd_i.sqrt_step && sbit_q == '0) begin
        bin_q <= (root_next > LastBin) ? LastBin : root_next;
      end else if (cmd_i.emit_init) begin
        bin_q <= '0;
      end else if (cmd_i.emit_out) begin
        bin_q <= bin_q + BinW'(1);
      end
      if (cmd_i.acc_wr) begin
        valid_q[bin_q] <= 1'b1;
      end else if (cmd_i.emit_out) begin
        valid_q[bin_q] <= 1'b0;
      end
    end
  end

  assign sts_o.z_ok      = (req_q.z_index <= HalfGrid);
  assign sts_o.sqrt_last = (sbit_q == '0);
  assign sts_o.div_last  = (dcnt_q == '0);
  assign sts_o.last_bin  = (bin_q == LastBin);

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

endmodule
`default_nettype wire

// ----- rtl/core/radial_power_spectrum_binner.sv -----
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+------------------------------
// request   | start_i, busy_o, request_i (req_t)      | taken when start_i && !busy_o
// result    | result_valid_o, result_o (rsp_t)        | one-cycle strobe, no stall
//
// An accumulate request runs capture, squares, six steps of the shared bit-serial
// square root, then a read and a write of the bin memory; one with a z index above
// half the grid ends after the squares. A finish request sweeps 56 bins in all, each
// with a memory read, a load and 50 steps of the restoring divider.
// Reset clears the controller and the per-bin valid bits, so every bin reads
// as empty without a clearing pass. The receiver cannot stall results.
`default_nettype none
module radial_power_spectrum_binner import rpsb_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  output logic      busy_o,
  input  wire req_t request_i,
  output rsp_t      result_o,
  output logic      result_valid_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    is_finish;

  assign is_finish = (request_i.command == CmdFinish);

  // The controller sequences each request; the datapath holds all payload.
  rpsb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .finish_i (is_finish),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  rpsb_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (request_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (result_o),
    .rsp_valid_o (result_valid_o)
  );

  // A finish request keeps the block busy for the emit that follows.
  a_finish_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && is_finish |=> busy_o)
    else $error("finish request did not raise busy");

  // Any result but the final one arrives while the sweep is still running.
  a_result_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |-> busy_o)
    else $error("result outside of the emit sweep");

  // An empty bin reports a zero mean.
  a_empty_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.point_count == '0 |-> result_o.mean_power == '0)
    else $error("empty bin with nonzero mean");

  // The final result closes the sweep.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last |-> !busy_o)
    else $error("sweep still running after the final bin");

endmodule
`default_nettype wire
